>>> src/ltao_pkg.sv
// Shared types, codes and defaults for the LRU tag array.
package ltao_pkg;

  localparam int SETS_DEF    = 256;
  localparam int WAYS_DEF    = 8;
  localparam int ID_BITS_DEF = 8;
  localparam int ADDR_W      = 40;

  typedef enum logic [2:0] {
    ACT_UP_OCC  = 3'd0,
    ACT_DN_OCC  = 3'd1,
    ACT_UP_FIND = 3'd2,
    ACT_DN_FIND = 3'd3,
    ACT_WRITE   = 3'd4
  } action_t;

  localparam logic [1:0] PICK_HIT     = 2'd0;
  localparam logic [1:0] PICK_INVALID = 2'd1;
  localparam logic [1:0] PICK_LRU     = 2'd2;
  localparam logic [1:0] PICK_NONE    = 2'd3;

  typedef struct packed {
    logic [2:0]        action;
    logic [ADDR_W-1:0] line_addr;
    logic [7:0]        req_id;
    logic [2:0]        write_way;
    logic              write_valid;
    logic [7:0]        write_up_id;
    logic [7:0]        write_down_id;
  } req_t;

  typedef struct packed {
    logic              found;
    logic [2:0]        way_index;
    logic [1:0]        pick_kind;
    logic [ADDR_W-1:0] old_tag_addr;
    logic              old_valid;
    logic              fault;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_READ,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic load;
    logic rd_in;
    logic rd_rem;
    logic mod_step;
    logic exec;
    logic clr;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic mod_last;
  } status_t;

endpackage

>>> src/ltao_dp.sv
// Datapath: set memory, set index remainder, way search, update and result register.
module ltao_dp #(
  parameter int SETS    = ltao_pkg::SETS_DEF,
  parameter int WAYS    = ltao_pkg::WAYS_DEF,
  parameter int ID_BITS = ltao_pkg::ID_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  ltao_pkg::req_t   req,
  input  ltao_pkg::cmd_t   cmd,
  output ltao_pkg::status_t status,
  output ltao_pkg::rsp_t   rsp
);
  import ltao_pkg::*;

  localparam int IW    = ID_BITS;
  localparam int WB    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int RB    = WB;
  localparam int SB    = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int EW    = ADDR_W + 1 + 2 * IW + RB;
  localparam int ROW_W = WAYS * EW;
  localparam int NB    = ADDR_W / 8;
  localparam int FW    = 27;

  // weight of each address byte modulo SETS
  function automatic logic [NB*16-1:0] fold_weights();
    logic [NB*16-1:0] c;
    longint unsigned  p;
    c = '0;
    p = 1;
    for (int i = 0; i < NB; i++) begin
      c[i*16 +: 16] = 16'(p % 64'(SETS));
      p = (p * 64'd256) % 64'(SETS);
    end
    return c;
  endfunction

  localparam logic [NB*16-1:0] FOLD_W = fold_weights();
  localparam logic [FW:0]      RECIP  = (FW+1)'((64'd1 << FW) / 64'(SETS));

  function automatic logic [WAYS-1:0] lowest(input logic [WAYS-1:0] m,
                                              input logic [WAYS*RB-1:0] rk);
    logic [WAYS-1:0] r;
    r = m;
    for (int w = 0; w < WAYS; w++) begin
      for (int v = 0; v < WAYS; v++) begin
        if (m[v] && (rk[v*RB +: RB] < rk[w*RB +: RB])) begin
          r[w] = 1'b0;
        end
      end
    end
    return r;
  endfunction

  logic [ROW_W-1:0]  mem [SETS];
  logic [ROW_W-1:0]  rd_q;
  logic [SB-1:0]     idx_q;
  logic [SB-1:0]     cnt;
  logic [SB:0]       rem;
  logic [1:0]        mstep;
  logic [FW-1:0]     fold_q;
  logic [FW-1:0]     qest_q;
  req_t              in_q;

  logic              rd_en;
  logic [SB-1:0]     rd_addr;
  logic              wr_en;
  logic [SB-1:0]     wr_addr;
  logic [ROW_W-1:0]  wr_data;
  logic [ROW_W-1:0]  clear_row;
  logic [ROW_W-1:0]  new_row;
  logic [FW-1:0]     fold_sum;
  logic [2*FW-1:0]   prod;
  logic [FW-1:0]     qd;
  logic [FW-1:0]     diff;
  logic [SB:0]       rem_fix;

  logic [ADDR_W-1:0] tag   [WAYS];
  logic              vld   [WAYS];
  logic [IW-1:0]     up    [WAYS];
  logic [IW-1:0]     dn    [WAYS];
  logic [RB-1:0]     rank  [WAYS];
  logic [WAYS*RB-1:0] rk_vec;
  logic [WAYS-1:0]   m_hit, m_inv, m_any, m_upf;
  logic [WAYS-1:0]   b_hit, b_inv, b_any, b_upf;
  logic [WAYS-1:0]   oh;
  logic [IW+7:0]     id_ext, wup_ext, wdn_ext;
  logic [IW-1:0]     id;
  logic [5:0]        ww_ext;
  logic              ww_ok;
  logic [WB-1:0]     sel_idx;
  logic [WB+2:0]     sel_ext;
  logic [RB-1:0]     sel_rank;
  logic [ADDR_W-1:0] sel_tag;
  logic              sel_vld;
  logic [1:0]        kind;
  logic              promote;
  logic              set_up;
  logic              set_dn;
  logic              do_write;
  logic [EW-1:0]     e;
  logic [RB-1:0]     nrank;
  logic [IW-1:0]     nup, ndn;
  logic [ADDR_W-1:0] ntag;
  logic              nvld;
  rsp_t              rsp_next;

  assign status.clr_last = (cnt == SB'(SETS - 1));
  assign status.mod_last = (mstep == 2'd3);

  assign rd_en   = cmd.rd_in | cmd.rd_rem;
  assign rd_addr = cmd.rd_in ? (req.line_addr[SB-1:0] & SB'(SETS - 1)) : rem[SB-1:0];
  assign wr_en   = cmd.clr | cmd.exec;
  assign wr_addr = cmd.clr ? cnt : idx_q;
  assign wr_data = cmd.clr ? clear_row : new_row;

  always_comb begin
    fold_sum = '0;
    for (int i = 0; i < NB; i++) begin
      fold_sum = fold_sum + (FW'(in_q.line_addr[i*8 +: 8]) * FW'(FOLD_W[i*16 +: 16]));
    end
  end

  assign prod    = (2*FW)'(fold_q) * (2*FW)'(RECIP);
  assign qd      = qest_q * FW'(SETS);
  assign diff    = fold_q - qd;
  assign rem_fix = (rem >= (SB+1)'(SETS)) ? rem - (SB+1)'(SETS) : rem;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q  <= mem[rd_addr];
      idx_q <= rd_addr;
    end
    if (cmd.load) begin
      in_q  <= req;
      mstep <= '0;
    end else if (cmd.mod_step) begin
      mstep <= mstep + 2'd1;
      unique case (mstep)
        2'd0:    fold_q <= fold_sum;
        2'd1:    qest_q <= prod[2*FW-1:FW];
        2'd2:    rem    <= diff[SB:0];
        default: rem    <= rem_fix;
      endcase
    end
    if (cmd.exec) begin
      rsp <= rsp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.clr) begin
      cnt <= cnt + SB'(1);
    end
  end

  always_comb begin
    clear_row = '0;
    for (int w = 0; w < WAYS; w++) begin
      clear_row[w*EW +: RB] = RB'(w);
    end
  end

  always_comb begin
    id_ext  = {{IW{1'b0}}, in_q.req_id};
    wup_ext = {{IW{1'b0}}, in_q.write_up_id};
    wdn_ext = {{IW{1'b0}}, in_q.write_down_id};
    id      = id_ext[IW-1:0];
    ww_ext  = {3'b000, in_q.write_way};
    ww_ok   = ww_ext < 6'(WAYS);
    for (int w = 0; w < WAYS; w++) begin
      e       = rd_q[w*EW +: EW];
      tag[w]  = e[EW-1 -: ADDR_W];
      vld[w]  = e[RB + 2*IW];
      up[w]   = e[RB + IW +: IW];
      dn[w]   = e[RB +: IW];
      rank[w] = e[RB-1:0];
      rk_vec[w*RB +: RB] = e[RB-1:0];
      m_hit[w] = vld[w] && (tag[w] == in_q.line_addr);
      m_inv[w] = !vld[w] && (up[w] == '0) && (dn[w] == '0);
      m_any[w] = (up[w] == '0) && (dn[w] == '0);
      m_upf[w] = (tag[w] == in_q.line_addr) && (up[w] == id) && (dn[w] == '0);
    end
  end

  assign b_hit = lowest(m_hit, rk_vec);
  assign b_inv = lowest(m_inv, rk_vec);
  assign b_any = lowest(m_any, rk_vec);
  assign b_upf = lowest(m_upf, rk_vec);

  always_comb begin
    oh       = '0;
    kind     = PICK_HIT;
    promote  = 1'b0;
    set_up   = 1'b0;
    set_dn   = 1'b0;
    do_write = 1'b0;
    unique case (in_q.action)
      ACT_UP_OCC: begin
        promote = 1'b1;
        set_up  = 1'b1;
        if (|m_hit) begin
          oh = b_hit;
        end else if (|m_inv) begin
          oh   = b_inv;
          kind = PICK_INVALID;
        end else begin
          oh   = b_any;
          kind = PICK_LRU;
        end
      end
      ACT_DN_OCC: begin
        oh     = b_hit;
        set_dn = 1'b1;
      end
      ACT_UP_FIND: oh = b_upf;
      ACT_DN_FIND: oh = b_hit;
      ACT_WRITE: begin
        do_write = 1'b1;
        for (int w = 0; w < WAYS; w++) begin
          oh[w] = ww_ok && (ww_ext == 6'(w));
        end
      end
      default: oh = '0;
    endcase
  end

  always_comb begin
    sel_idx  = '0;
    sel_rank = '0;
    sel_tag  = '0;
    sel_vld  = 1'b0;
    for (int w = 0; w < WAYS; w++) begin
      if (oh[w]) begin
        sel_idx  = sel_idx | WB'(w);
        sel_rank = sel_rank | rank[w];
        sel_tag  = sel_tag | tag[w];
        sel_vld  = sel_vld | vld[w];
      end
    end
    sel_ext = {3'b000, sel_idx};
  end

  always_comb begin
    new_row = rd_q;
    for (int w = 0; w < WAYS; w++) begin
      nrank = rank[w];
      nup   = up[w];
      ndn   = dn[w];
      ntag  = tag[w];
      nvld  = vld[w];
      if (promote && (|oh)) begin
        if (oh[w]) begin
          nrank = RB'(WAYS - 1);
        end else if (rank[w] > sel_rank) begin
          nrank = rank[w] - RB'(1);
        end
      end
      if (oh[w]) begin
        if (set_up) begin
          nup = id;
        end
        if (set_dn) begin
          ndn = id;
        end
        if (do_write) begin
          ntag = in_q.line_addr;
          nvld = in_q.write_valid;
          nup  = wup_ext[IW-1:0];
          ndn  = wdn_ext[IW-1:0];
        end
      end
      new_row[w*EW +: EW] = {ntag, nvld, nup, ndn, nrank};
    end
  end

  always_comb begin
    if (|oh) begin
      rsp_next.found        = 1'b1;
      rsp_next.way_index    = sel_ext[2:0];
      rsp_next.pick_kind    = (in_q.action == ACT_UP_OCC) ? kind : PICK_HIT;
      rsp_next.old_tag_addr = sel_tag;
      rsp_next.old_valid    = sel_vld;
      rsp_next.fault        = 1'b0;
    end else begin
      rsp_next = '0;
      rsp_next.fault = 1'b1;
    end
  end

endmodule

>>> src/ltao_ctrl.sv
// Controller: clearing pass, set index remainder, read and update sequencing.
module ltao_ctrl #(
  parameter int SETS = ltao_pkg::SETS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  input  ltao_pkg::status_t status,
  output ltao_pkg::cmd_t    cmd
);
  import ltao_pkg::*;

  localparam bit POW2 = ((SETS & (SETS - 1)) == 0);

  state_t state, state_next;
  logic   rsp_free;

  assign rsp_free = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.exec) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (status.clr_last) state_next = ST_IDLE;
      ST_IDLE:  if (req_valid) state_next = POW2 ? ST_EXEC : ST_MOD;
      ST_MOD:   if (status.mod_last) state_next = ST_READ;
      ST_READ:  state_next = ST_EXEC;
      ST_EXEC:  if (rsp_free) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    req_stall    = (state != ST_IDLE);
    cmd.load     = (state == ST_IDLE) && req_valid;
    cmd.rd_in    = (state == ST_IDLE) && req_valid && POW2;
    cmd.mod_step = (state == ST_MOD);
    cmd.rd_rem   = (state == ST_READ);
    cmd.exec     = (state == ST_EXEC) && rsp_free;
    cmd.clr      = (state == ST_CLEAR);
  end

endmodule

>>> src/lru_tag_array_occupancy.sv
// Top level of the set-associative tag array with true LRU order per set.
// Request channel (req_valid, req_stall, req) carries one action: up/down
// occupy, up/down find or write line. Response channel (rsp_valid,
// rsp_stall, rsp) returns exactly one result per request, in order.
// With SETS a power of two the set row of a request is read from the set
// memory, then all ways are compared and the row written back.
// Otherwise the set index is formed first by a weighted fold of the address
// bytes, a reciprocal multiply, a subtract and a correction, then the row
// is read, compared and written back.
// One request is in flight at a time; req_stall is low only when idle.
// The response sits in an output register; a stalled response holds, and
// the next request is taken meanwhile but its update waits for the slot.
// After reset a clearing pass writes every row (tags, valid
// marks and occupants zero, LRU rank equal to way number); requests are
// stalled until it ends. Results are visible the cycle after the update.
module lru_tag_array_occupancy #(
  parameter int SETS    = ltao_pkg::SETS_DEF,
  parameter int WAYS    = ltao_pkg::WAYS_DEF,
  parameter int ID_BITS = ltao_pkg::ID_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  ltao_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output ltao_pkg::rsp_t rsp
);
  import ltao_pkg::*;

  cmd_t    cmd;
  status_t status;

  ltao_ctrl #(.SETS(SETS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .status    (status),
    .cmd       (cmd)
  );

  ltao_dp #(.SETS(SETS), .WAYS(WAYS), .ID_BITS(ID_BITS)) u_dp (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .cmd    (cmd),
    .status (status),
    .rsp    (rsp)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("request taken while a transaction is in flight");

  a_found_xor_fault: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.found != rsp.fault))
    else $error("found and fault disagree");

  a_fault_clean: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.fault) |-> (rsp.way_index == 3'd0 && rsp.old_valid == 1'b0))
    else $error("failed transaction carries way data");

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.pick_kind != PICK_NONE))
    else $error("illegal pick kind");

endmodule
